>>> rtl/core/content_defined_chunk_boundary_defines.svh
// ---------------------------------------------------------------------------
// content_defined_chunk_boundary_defines
// assertion macros shared by the chunk boundary rtl
// ---------------------------------------------------------------------------
`ifndef CONTENT_DEFINED_CHUNK_BOUNDARY_DEFINES_SVH
`define CONTENT_DEFINED_CHUNK_BOUNDARY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define CDCB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CDCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDCB_ASSERT_SAME(lbl, ante, cons, msg)
`define CDCB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/cdcb_pkg.sv
// ---------------------------------------------------------------------------
// cdcb_pkg
// types, constants and tap tables for the chunk boundary detector
// ---------------------------------------------------------------------------
package cdcb_pkg;

    localparam int WINDOW_LEN_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int FP_W           = 20;
    localparam int TERM_W         = 17;
    localparam int MASK_W         = 3;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [31:0] TAP_BASE = 32'd1048583;
    localparam logic [31:0] TAP_MOD  = 32'd100000;
    localparam logic [31:0] HASH_MOD = 32'd1000000;

    localparam logic [MASK_W-1:0] MASK_RESET = 3'd5;

    // register index codes (byte address bit 2 selects the register)
    localparam logic REG_MASK_BITS = 1'b0;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [FP_W-1:0]   fp_t;
    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [TERM_W-1:0] term_lut_t [256];

    // tap k is the base raised to k+1, wrapped to 32 bits and reduced at each step
    function automatic logic [TERM_W-1:0] tap_of(input int k);
        logic [31:0] acc;
        logic [63:0] prod;
        acc = 32'd1;
        for (int i = 0; i <= k; i++)
        begin
            prod = 64'(acc) * 64'(TAP_BASE);
            acc  = prod[31:0] % TAP_MOD;
        end
        return TERM_W'(acc);
    endfunction

    // per-byte reduced product for one tap position
    function automatic term_lut_t build_lut(input int k);
        term_lut_t   lut;
        logic [31:0] tap;
        logic [31:0] prod;
        tap = 32'(tap_of(k));
        for (int b = 0; b < 256; b++)
        begin
            prod   = 32'(b) * tap;
            lut[b] = TERM_W'(prod % TAP_MOD);
        end
        return lut;
    endfunction

endpackage

>>> rtl/core/cdcb_cell.sv
// ---------------------------------------------------------------------------
// cdcb_cell
// one tap of the transposed window hash: adds its term to the neighbor's sum
// ---------------------------------------------------------------------------
module cdcb_cell #(
    parameter int TAP_IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift_en,
    input  cdcb_pkg::byte_t data_byte,
    input  cdcb_pkg::fp_t   sum_in,
    output cdcb_pkg::fp_t   sum_next,
    output cdcb_pkg::fp_t   sum_reg
);
    import cdcb_pkg::*;

    localparam term_lut_t TERM_LUT = build_lut(TAP_IDX);

    logic [TERM_W-1:0] term;
    logic [FP_W:0]     wide;

    // term lookup and modular add
    always_comb
    begin
        term = TERM_LUT[data_byte];
        wide = {1'b0, sum_in} + (FP_W+1)'(term);
        if (wide >= (FP_W+1)'(HASH_MOD))
            sum_next = FP_W'(wide - (FP_W+1)'(HASH_MOD));
        else
            sum_next = FP_W'(wide);
    end

    // partial sum handed to the next cell toward the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (shift_en)
            sum_reg <= sum_next;
    end

endmodule

>>> rtl/core/content_defined_chunk_boundary.sv
// ---------------------------------------------------------------------------
// content_defined_chunk_boundary: windowed fingerprint and chunk cut detector
// one byte per cycle unless the result channel stalls; result registered, valid in the cycle after acceptance
// critical path: tap table lookup, 21-bit modular add, mask test, fill count
// reset clears all partial sums (zero window), fill count, valid; mask_bits 5
// ---------------------------------------------------------------------------
`include "content_defined_chunk_boundary_defines.svh"

module content_defined_chunk_boundary #(
    parameter int WINDOW_LEN = cdcb_pkg::WINDOW_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // byte channel
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  cdcb_pkg::byte_t             data_byte,
    input  logic                        packet_start,
    // result channel
    output logic                        result_valid,
    input  logic                        result_ready,
    output cdcb_pkg::fp_t               fingerprint,
    output logic                        window_full,
    output logic                        cut,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdcb_pkg::APB_AW-1:0] paddr,
    input  logic [cdcb_pkg::APB_DW-1:0] pwdata,
    output logic [cdcb_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import cdcb_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    logic             byte_acc;
    logic             cfg_wr;
    mask_t            mask_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_base;
    logic [CNT_W-1:0] fill_next;
    logic             full_next;
    logic             cut_next;
    logic [7:0]       low_mask;
    fp_t              fp_next;
    logic             result_valid_reg;
    logic             full_reg;
    logic             cut_reg;
    fp_t              chain [WINDOW_LEN+1];
    fp_t              cell_sum [WINDOW_LEN];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_MASK_BITS) ? APB_DW'(mask_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= MASK_RESET;
        else if (cfg_wr && paddr[2] == REG_MASK_BITS)
            mask_reg <= pwdata[MASK_W-1:0];
    end

    // handshake: output register frees up when taken
    assign byte_ready = !result_valid_reg || result_ready;
    assign byte_acc   = byte_valid & byte_ready;

    // chain of tap cells, oldest tap at the far end
    assign chain[WINDOW_LEN] = '0;

    for (genvar k = 0; k < WINDOW_LEN; k++)
    begin : g_cell
        cdcb_cell #(
            .TAP_IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (byte_acc),
            .data_byte (data_byte),
            .sum_in    (chain[k+1]),
            .sum_next  (cell_sum[k]),
            .sum_reg   (chain[k])
        );
    end

    // new fingerprint comes from the head cell
    assign fp_next = cell_sum[0];

    // fill count and cut decision
    always_comb
    begin
        if (packet_start)
            fill_base = CNT_W'(1);
        else if (fill_reg < CNT_W'(WINDOW_LEN))
            fill_base = fill_reg + CNT_W'(1);
        else
            fill_base = fill_reg;
        full_next = (fill_base >= CNT_W'(WINDOW_LEN));
        low_mask  = 8'((9'd1 << mask_reg) - 9'd1);
        cut_next  = full_next && ((fp_next[7:0] & low_mask) == 8'd0);
        fill_next = cut_next ? '0 : fill_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
            full_reg         <= 1'b0;
            cut_reg          <= 1'b0;
        end
        else
        begin
            if (byte_acc)
            begin
                fill_reg <= fill_next;
                full_reg <= full_next;
                cut_reg  <= cut_next;
            end
            if (byte_acc)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign fingerprint  = chain[0];
    assign window_full  = full_reg;
    assign cut          = cut_reg;

    // checks
    `CDCB_ASSERT_SAME(a_cut_needs_full, result_valid_reg && cut_reg, full_reg, "cut without full")
    `CDCB_ASSERT_NEXT(a_cut_clears_fill, byte_acc && cut_next, fill_reg == '0, "fill not cleared")
    `CDCB_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= CNT_W'(WINDOW_LEN), "fill over window")
    `CDCB_ASSERT_SAME(a_fp_range, result_valid_reg, chain[0] < FP_W'(HASH_MOD), "fp out of range")
    `CDCB_ASSERT_SAME(a_no_overrun, result_valid_reg && !result_ready, !byte_ready, "overrun")

endmodule

>>> verif/content_defined_chunk_boundary_tb.sv
// ---------------------------------------------------------------------------
// content_defined_chunk_boundary_tb
// drives payload bytes through the chunk boundary detector and checks every
// fingerprint, window-full flag and cut against an in-bench predictor of the
// 32-byte windowed hash, over several mask widths set through the apb port
// ---------------------------------------------------------------------------
module content_defined_chunk_boundary_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdcb_pkg::*;

    localparam int WIN          = WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int NUM_PHASES   = 8;

    // apb byte addresses: register i at 4*i
    localparam logic [APB_AW-1:0] MASK_BITS_ADDR = APB_AW'({REG_MASK_BITS, 2'b00});
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR  = APB_AW'(4);

    typedef struct packed {
        fp_t  fp;
        logic full;
        logic cut;
    } chunk_result_t;

    // predictor of the windowed fingerprint and the chunk cuts
    class fingerprint_tracker;
        logic [31:0]   taps [WIN];
        byte_t         window_bytes [WIN];
        int unsigned   fill;
        mask_t         mask_width;
        chunk_result_t expected_q [$];
        int            errors;

        function new();
            logic [31:0] acc;
            acc = 32'd1;
            // tap k = base^(k+1), wrapped to 32 bits and reduced each step
            for (int k = 0; k < WIN; k++)
            begin
                acc     = acc * TAP_BASE;
                acc     = acc % TAP_MOD;
                taps[k] = acc;
            end
            foreach (window_bytes[k])
                window_bytes[k] = '0;
            fill       = 0;
            mask_width = MASK_RESET;
            errors     = 0;
        endfunction

        function void set_mask(mask_t m);
            mask_width = m;
        endfunction

        function int count();
            return expected_q.size();
        endfunction

        // shift in one accepted byte and queue the expected result
        function void note_byte(byte_t b, logic start);
            logic [31:0]   sum;
            logic [31:0]   lowmask;
            chunk_result_t r;
            sum = '0;
            for (int k = WIN - 1; k > 0; k--)
                window_bytes[k] = window_bytes[k-1];
            window_bytes[0] = b;
            for (int k = 0; k < WIN; k++)
                sum += (32'(window_bytes[k]) * taps[k]) % TAP_MOD;
            r.fp = FP_W'(sum % HASH_MOD);
            if (start)
                fill = 1;
            else if (fill < WIN)
                fill++;
            r.full  = (fill >= WIN);
            lowmask = (32'd1 << mask_width) - 32'd1;
            r.cut   = r.full && ((32'(r.fp) & lowmask) == 0);
            if (r.cut)
                fill = 0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(fp_t fp, logic full, logic c);
            chunk_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result fingerprint", fp, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (fp !== want.fp)
                    report_mismatch("fingerprint", fp, want.fp);
                if (full !== want.full)
                    report_mismatch("window_full", full, want.full);
                if (c !== want.cut)
                    report_mismatch("cut", c, want.cut);
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_ready;
    byte_t              data_byte;
    logic               packet_start;
    logic               result_valid;
    logic               result_ready;
    fp_t                fingerprint;
    logic               window_full;
    logic               cut;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    fingerprint_tracker tracker = new();
    int                 cycle_count = 0;
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    bit                 hold_request = 1'b0;

    content_defined_chunk_boundary dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .packet_start (packet_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .fingerprint  (fingerprint),
        .window_full  (window_full),
        .cut          (cut),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // transaction monitor: results first, then accepted bytes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                tracker.check_result(fingerprint, window_full, cut);
            if (byte_valid && byte_ready)
                tracker.note_byte(data_byte, packet_start);
        end
    end

    // result receiver: random stall bursts and one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                result_ready = 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                result_ready = 1'b0;
                stall_left   = $urandom_range(1, 6) - 1;
            end
            else
            begin
                result_ready = 1'b1;
            end
        end
    end

    // offer one byte, with an occasional idle burst first
    task send_byte(input byte_t b, input logic start);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap        = $urandom_range(1, 6);
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid   = 1'b1;
        data_byte    = b;
        packet_start = start;
        do
            @(posedge clk);
        while (!byte_ready);
        @(negedge clk);
    endtask

    // one packet of random shape; returns the number of bytes sent
    task send_packet(output int len);
        int    shape;
        int    kind;
        byte_t fill_byte;
        byte_t b;
        logic  start;
        shape = $urandom_range(0, 9);
        if (shape < 2)
            len = $urandom_range(1, 8);
        else if (shape < 8)
            len = $urandom_range(20, 120);
        else
            len = $urandom_range(121, 300);
        kind      = $urandom_range(0, 9);
        fill_byte = byte_t'($urandom);
        for (int i = 0; i < len; i++)
        begin
            start = (i == 0);
            case (kind)
                6, 7:    b = ($urandom_range(0, 7) == 0) ? byte_t'($urandom) : '0;
                8:       b = fill_byte;
                default: b = byte_t'($urandom);
            endcase
            // stray packet start in the middle of a packet
            if (kind == 9 && $urandom_range(0, 39) == 0)
                start = 1'b1;
            send_byte(b, start);
        end
    endtask

    // apb write: setup cycle then access cycle
    task apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == MASK_BITS_ADDR)
            tracker.set_mask(value[MASK_W-1:0]);
    endtask

    // hold the byte side until every expected result is back
    task wait_drained();
        byte_valid = 1'b0;
        while (tracker.count() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        byte_t directed_bytes [24];
        mask_t phase_masks [NUM_PHASES];
        int    sent;
        int    len;

        directed_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE,
                           8'hAA, 8'h55, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02,
                           8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hC3, 8'h3C};
        phase_masks    = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd2, 3'd4, 3'd5};

        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        data_byte    = '0;
        packet_start = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: byte extremes and walking bits, packet starts back to back
        // and in mid-stream (window kept, count restarted), reset mask width
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i], (i == 0 || i == 12 || i == 13));

        // random packets over a series of mask widths, zero and seven included
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            // write to an unmapped register must not disturb the mask
            if (p == 4)
                apb_write(UNMAPPED_ADDR, $urandom);
            apb_write(MASK_BITS_ADDR, {29'($urandom), phase_masks[p]});
            if (p == 2)
                hold_request = 1'b1;
            if (p == NUM_PHASES - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_packet(len);
                sent += len;
            end
        end

        // drain and finish
        wait_drained();
        if (tracker.errors == 0 && tracker.count() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
